/* sv/vpid_pkg.sv */
package vpid_pkg;

    localparam int CFG_AW = 3;

    // register index on the configuration channel
    typedef enum logic [CFG_AW-1:0] {
        CFG_KP    = 3'd0,
        CFG_IRAT  = 3'd1,
        CFG_DRAT  = 3'd2,
        CFG_FC    = 3'd3,
        CFG_BETA  = 3'd4,
        CFG_GAMMA = 3'd5,
        CFG_OMIN  = 3'd6,
        CFG_OMAX  = 3'd7
    } t_cfg_idx;

    localparam logic [16:0]        Q_ONE     = 17'd65536;
    localparam logic [16:0]        FC_RST    = 17'd59578;
    localparam logic signed [31:0] BETA_RST  = 32'sd65536;
    localparam logic signed [65:0] Q_HALF    = 66'sd32768;
    localparam logic signed [63:0] SAT_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN   = -64'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EN,
        ST_EP,
        ST_ED,
        ST_II,
        ST_EDT,
        ST_EDF,
        ST_PD,
        ST_SD,
        ST_IIP,
        ST_INNER,
        ST_KP,
        ST_DU,
        ST_SUM,
        ST_CLAMP
    } t_state;

    typedef struct packed {
        logic signed [32:0] mul_a;
        logic signed [32:0] mul_b;
        logic signed [63:0] add_a;
        logic signed [63:0] add_b;
        logic signed [63:0] add_c;
    } t_alu_req;

    typedef struct packed {
        logic signed [63:0] q;
        logic signed [63:0] sum;
        logic signed [31:0] sat;
    } t_alu_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (x < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/vpid_alu.sv */
module vpid_alu
    import vpid_pkg::*;
(
    input  logic     i_clk,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic signed [32:0] w_a;
    logic signed [32:0] w_b;
    logic signed [65:0] r_prod;
    logic signed [65:0] w_rnd;
    logic signed [65:0] w_q66;
    logic signed [63:0] w_x;
    logic signed [63:0] w_y;
    logic signed [63:0] w_z;
    logic signed [63:0] w_sum;

    assign w_a = i_req.mul_a;
    assign w_b = i_req.mul_b;

    // product registered, consumed in the following cycle
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
    end

    // round half up back to q16.16
    assign w_rnd = r_prod + Q_HALF;
    assign w_q66 = w_rnd >>> 16;

    assign w_x   = i_req.add_a;
    assign w_y   = i_req.add_b;
    assign w_z   = i_req.add_c;
    assign w_sum = w_x + w_y + w_z;

    assign o_rsp.q   = w_q66[63:0];
    assign o_rsp.sum = w_sum;
    assign o_rsp.sat = sat32(w_sum);

endmodule

/* sv/velocity_pid_filtered_derivative.sv */
// channel   | dir | handshake                     | payload
// ----------+-----+-------------------------------+--------------------------------
// s stream  | in  | i_s_tvalid / o_s_tready       | i_s_tdata: measured, setpoint
// m stream  | out | o_m_tvalid / i_m_tready       | o_m_tdata: drive
// cfg write | in  | i_cfg_valid / o_cfg_ready     | i_cfg_addr, i_cfg_data
//
// one word at a time, taken only in idle; each word then runs 14 steps through one
// shared 33x33 multiplier and one three-input adder with saturation
// the result sits in an output register; the last step waits there while it is untaken
// reset is synchronous: configuration takes its defaults, history clears to zero
// the configuration channel is always ready
module velocity_pid_filtered_derivative
    import vpid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [63:0]       i_s_tdata,   // [31:0] measured, [63:32] setpoint
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,   // [31:0] drive
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]       i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic signed [31:0] r_kp, r_irat, r_drat, r_beta, r_gamma, r_omin, r_omax;
    logic [16:0]        r_fc;

    logic signed [31:0] r_ppe, r_fp, r_fp2, r_pdrv;

    logic signed [31:0] r_m, r_sp;
    logic signed [31:0] r_en, r_ep, r_ed, r_edf, r_pd, r_sd, r_inner, r_du;
    logic signed [63:0] r_ii, r_t;

    logic               r_out_valid;
    logic signed [31:0] r_out;

    t_alu_req           w_req;
    t_alu_rsp           w_rsp;
    logic [16:0]        w_fc;
    logic [16:0]        w_fcn;
    logic               w_fin;
    logic signed [31:0] w_drive;

    vpid_alu u_alu (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // weight above one acts as one
    assign w_fc  = (r_fc > Q_ONE) ? Q_ONE : r_fc;
    assign w_fcn = Q_ONE - w_fc;

    // clamp, upper bound first
    always_comb begin
        if (r_t > 64'(r_omax)) begin
            w_drive = r_omax;
        end else if (r_t < 64'(r_omin)) begin
            w_drive = r_omin;
        end else begin
            w_drive = r_t[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_s_tvalid) n_state = ST_EN;
            ST_EN:    n_state = ST_EP;
            ST_EP:    n_state = ST_ED;
            ST_ED:    n_state = ST_II;
            ST_II:    n_state = ST_EDT;
            ST_EDT:   n_state = ST_EDF;
            ST_EDF:   n_state = ST_PD;
            ST_PD:    n_state = ST_SD;
            ST_SD:    n_state = ST_IIP;
            ST_IIP:   n_state = ST_INNER;
            ST_INNER: n_state = ST_KP;
            ST_KP:    n_state = ST_DU;
            ST_DU:    n_state = ST_SUM;
            ST_SUM:   n_state = ST_CLAMP;
            ST_CLAMP: if (w_fin) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // operand selection; each product is used by the adder one step later
    always_comb begin
        w_req      = '0;
        o_s_tready = 1'b0;
        w_fin      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_EN: begin
                w_req.mul_a = 33'(r_beta);
                w_req.mul_b = 33'(r_sp);
                w_req.add_a = 64'(r_sp);
                w_req.add_b = -64'(r_m);
            end
            ST_EP: begin
                w_req.mul_a = 33'(r_gamma);
                w_req.mul_b = 33'(r_sp);
                w_req.add_a = w_rsp.q;
                w_req.add_b = -64'(r_m);
            end
            ST_ED: begin
                w_req.mul_a = 33'(r_irat);
                w_req.mul_b = 33'(r_en);
                w_req.add_a = w_rsp.q;
                w_req.add_b = -64'(r_m);
            end
            ST_II: begin
                w_req.mul_a = 33'(r_ed);
                w_req.mul_b = {16'b0, w_fc};
                w_req.add_a = w_rsp.q;
            end
            ST_EDT: begin
                w_req.mul_a = 33'(r_fp);
                w_req.mul_b = {16'b0, w_fcn};
                w_req.add_a = w_rsp.q;
            end
            ST_EDF: begin
                w_req.add_a = w_rsp.q;
                w_req.add_b = r_t;
            end
            ST_PD: begin
                w_req.add_a = 64'(r_ep);
                w_req.add_b = -64'(r_ppe);
            end
            ST_SD: begin
                w_req.add_a = 64'(r_edf);
                w_req.add_b = -(64'(r_fp) <<< 1);
                w_req.add_c = 64'(r_fp2);
            end
            ST_IIP: begin
                w_req.mul_a = 33'(r_drat);
                w_req.mul_b = 33'(r_sd);
                w_req.add_a = 64'(r_pd);
                w_req.add_b = r_ii;
            end
            ST_INNER: begin
                w_req.add_a = w_rsp.q;
                w_req.add_b = r_ii;
            end
            ST_KP: begin
                w_req.mul_a = 33'(r_kp);
                w_req.mul_b = 33'(r_inner);
            end
            ST_DU: begin
                w_req.add_a = w_rsp.q;
            end
            ST_SUM: begin
                w_req.add_a = 64'(r_pdrv);
                w_req.add_b = 64'(r_du);
            end
            ST_CLAMP: begin
                w_fin = !r_out_valid || i_m_tready;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_m  <= i_s_tdata[31:0];
                r_sp <= i_s_tdata[63:32];
            end
            ST_EN:    r_en    <= w_rsp.sat;
            ST_EP:    r_ep    <= w_rsp.sat;
            ST_ED:    r_ed    <= w_rsp.sat;
            ST_II:    r_ii    <= w_rsp.sum;
            ST_EDT:   r_t     <= w_rsp.sum;
            ST_EDF:   r_edf   <= w_rsp.sat;
            ST_PD:    r_pd    <= w_rsp.sat;
            ST_SD:    r_sd    <= w_rsp.sat;
            ST_IIP:   r_ii    <= w_rsp.sum;
            ST_INNER: r_inner <= w_rsp.sat;
            ST_DU:    r_du    <= w_rsp.sat;
            ST_SUM:   r_t     <= w_rsp.sum;
            default: begin
            end
        endcase
        if (w_fin) begin
            r_out <= w_drive;
        end
    end

    // configuration and loop history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_irat  <= '0;
            r_drat  <= '0;
            r_fc    <= FC_RST;
            r_beta  <= BETA_RST;
            r_gamma <= '0;
            r_omin  <= '0;
            r_omax  <= '0;
            r_ppe   <= '0;
            r_fp    <= '0;
            r_fp2   <= '0;
            r_pdrv  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    CFG_KP:    r_kp    <= i_cfg_data;
                    CFG_IRAT:  r_irat  <= i_cfg_data;
                    CFG_DRAT:  r_drat  <= i_cfg_data;
                    CFG_FC:    r_fc    <= i_cfg_data[16:0];
                    CFG_BETA:  r_beta  <= i_cfg_data;
                    CFG_GAMMA: r_gamma <= i_cfg_data;
                    CFG_OMIN:  r_omin  <= i_cfg_data;
                    CFG_OMAX:  r_omax  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_fin) begin
                r_ppe  <= r_ep;
                r_fp2  <= r_fp;
                r_fp   <= r_edf;
                r_pdrv <= w_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;
    assign o_cfg_ready = 1'b1;

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_EN))
        else $error("accepted word did not start the sequence");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second word taken while busy");

    a_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (r_fp2 == $past(r_fp)))
        else $error("filtered derivative history shifted wrongly");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (o_m_tvalid && (o_m_tdata == $past(w_drive))))
        else $error("result word not presented after final step");

endmodule
